// ----- rtl/bsl_pkg.sv -----
`default_nettype none

package bsl_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // Derived widths
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Compare width covering start_index (4 bits) and the count
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  // Width able to carry the count into the 5-bit element_count field
  localparam int ECW   = (CNT_W > 5) ? CNT_W : 5;

  // Request codes
  localparam logic [2:0] ModePushBack  = 3'd0;
  localparam logic [2:0] ModePopBack   = 3'd1;
  localparam logic [2:0] ModePushFront = 3'd2;
  localparam logic [2:0] ModePopFront  = 3'd3;
  localparam logic [2:0] ModeFind      = 3'd4;

  // Result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusEmpty    = 2'd2;
  localparam logic [1:0] StatusNotFound = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the request beat
    logic exec;  // perform the captured request
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/bsl_ctrl.sv -----
`default_nettype none

module bsl_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output bsl_pkg::cmd_t    cmd_o,
  output logic             result_valid_o
);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  logic   accept;

  // A request is taken whenever no captured request is pending execution
  assign busy   = (state_q == StExec);
  assign accept = start && !busy;

  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == StExec);

  // State and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          state_q        <= StIdle;
          result_valid_o <= 1'b1;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bsl_datapath.sv -----
`default_nettype none

module bsl_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bsl_pkg::cmd_t      cmd_i,
  input  wire logic [2:0]         mode_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [3:0]         start_index_i,
  output logic [1:0]              status_o,
  output logic [3:0]              found_index_o,
  output logic [4:0]              element_count_o
);

  localparam int DW = bsl_pkg::DEPTH;
  localparam int WW = bsl_pkg::DATA_WIDTH;

  // Captured request
  logic [2:0]    mode_q;
  logic [WW-1:0] val_q;
  logic [3:0]    start_q;
  logic [WW-1:0] val_w;

  // List storage
  logic [WW-1:0]             entries_q [DW];
  logic [WW-1:0]             entries_d [DW];
  logic [bsl_pkg::CNT_W-1:0] count_q, count_d;

  // Result registers
  logic [1:0] status_q, status_d;
  logic [3:0] found_q, found_d;
  logic [4:0] ecount_q;

  logic                      full, empty;
  logic [DW-1:0]             hit;
  logic [bsl_pkg::CMP_W-1:0] found_w;
  logic [bsl_pkg::ECW-1:0]   ecount_w;

  // Fit the 32-bit value beat to the word width
  if (WW <= 32) begin : g_val_narrow
    assign val_w = value_i[WW-1:0];
  end else begin : g_val_wide
    assign val_w = {{(WW - 32){1'b0}}, value_i};
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      val_q   <= val_w;
      start_q <= start_index_i;
    end
  end

  assign full  = (count_q == bsl_pkg::CNT_W'(DW));
  assign empty = (count_q == '0);

  // Per-cell match within [start, count)
  always_comb begin
    for (int i = 0; i < DW; i++) begin
      hit[i] = (entries_q[i] == val_q)
            && (bsl_pkg::CMP_W'(i) >= bsl_pkg::CMP_W'(start_q))
            && (bsl_pkg::CMP_W'(i) <  bsl_pkg::CMP_W'(count_q));
    end
  end

  // Lowest matching position
  always_comb begin
    found_w = '0;
    for (int i = DW - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found_w = bsl_pkg::CMP_W'(i);
      end
    end
  end

  // Next list contents, count and result
  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    status_d  = bsl_pkg::StatusOk;
    found_d   = '0;
    unique case (mode_q)
      bsl_pkg::ModePushBack: begin
        if (full) begin
          status_d = bsl_pkg::StatusFull;
        end else begin
          for (int i = 0; i < DW; i++) begin
            if (bsl_pkg::CNT_W'(i) == count_q) begin
              entries_d[i] = val_q;
            end
          end
          count_d = count_q + 1'b1;
        end
      end
      bsl_pkg::ModePopBack: begin
        if (empty) begin
          status_d = bsl_pkg::StatusEmpty;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      bsl_pkg::ModePushFront: begin
        if (full) begin
          status_d = bsl_pkg::StatusFull;
        end else begin
          // Every cell takes its lower neighbor; cell 0 takes the value
          entries_d[0] = val_q;
          for (int i = 1; i < DW; i++) begin
            entries_d[i] = entries_q[i-1];
          end
          count_d = count_q + 1'b1;
        end
      end
      bsl_pkg::ModePopFront: begin
        if (empty) begin
          status_d = bsl_pkg::StatusEmpty;
        end else begin
          // Every cell takes its upper neighbor; the top cell is stale
          for (int i = 0; i < DW - 1; i++) begin
            entries_d[i] = entries_q[i+1];
          end
          count_d = count_q - 1'b1;
        end
      end
      bsl_pkg::ModeFind: begin
        if (|hit) begin
          found_d = found_w[3:0];
        end else begin
          status_d = bsl_pkg::StatusNotFound;
        end
      end
      default: begin
      end
    endcase
  end

  assign ecount_w = bsl_pkg::ECW'(count_d);

  // Storage update
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      entries_q <= entries_d;
      status_q  <= status_d;
      found_q   <= found_d;
      ecount_q  <= ecount_w[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign status_o        = status_q;
  assign found_index_o   = found_q;
  assign element_count_o = ecount_q;

endmodule

`default_nettype wire

// ----- rtl/bounded_sequence_list_unit.sv -----
// Channel   Handshake                   Payload
// request   start, busy (in: start&!busy) mode_i, value_i, start_index_i
// result    result_valid_o (one cycle)  status_o, found_index_o, element_count_o
//
// Each request is first captured from the beat; then the cell row writes,
// shifts or compares entries and updates the count. The result and its
// strobe are registered as that step ends, and the next request may already
// be captured while the result is shown, but never while busy is high.
// Reset clears the count and the control state; entry contents are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module bounded_sequence_list_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         mode_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [3:0]         start_index_i,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic [3:0]              found_index_o,
  output logic [4:0]              element_count_o
);

  bsl_pkg::cmd_t cmd;

  // Sequencer
  bsl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o)
  );

  // List storage and result logic
  bsl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .mode_i          (mode_i),
    .value_i         (value_i),
    .start_index_i   (start_index_i),
    .status_o        (status_o),
    .found_index_o   (found_index_o),
    .element_count_o (element_count_o)
  );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

module testbench;
  import bsl_pkg::*;

  // Unused request codes, ignored by the block
  localparam logic [2:0] ModeSpare5 = 3'd5;
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  localparam int RandomItems = 850;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] found_index;
    logic [4:0] element_count;
  } list_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               req_start = 1'b0;
  logic [2:0]         req_mode = ModePushBack;
  logic signed [31:0] req_value = '0;
  logic [3:0]         req_start_index = '0;
  logic               busy;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic [3:0]         found_index_o;
  logic [4:0]         element_count_o;

  // Shadow copy of the list contents and length
  logic [DATA_WIDTH-1:0] list_mem [DEPTH];
  int                    list_len = 0;

  list_result_t expected_results [$];
  int           error_count = 0;

  bounded_sequence_list_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (req_start),
    .busy           (busy),
    .mode_i         (req_mode),
    .value_i        (req_value),
    .start_index_i  (req_start_index),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_index_o  (found_index_o),
    .element_count_o(element_count_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one request to the shadow list and return the result it should give
  function automatic list_result_t apply_list_request(logic [2:0] mode,
                                                      logic [DATA_WIDTH-1:0] value,
                                                      logic [3:0] first_pos);
    list_result_t res;
    int           i;
    bit           hit;
    res.status      = StatusOk;
    res.found_index = '0;
    hit             = 1'b0;
    case (mode)
      ModePushBack: begin
        if (list_len >= DEPTH) begin
          res.status = StatusFull;
        end else begin
          list_mem[list_len] = value;
          list_len++;
        end
      end
      ModePopBack: begin
        if (list_len == 0) res.status = StatusEmpty;
        else list_len--;
      end
      ModePushFront: begin
        if (list_len >= DEPTH) begin
          res.status = StatusFull;
        end else begin
          for (i = list_len; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = value;
          list_len++;
        end
      end
      ModePopFront: begin
        if (list_len == 0) begin
          res.status = StatusEmpty;
        end else begin
          for (i = 0; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ModeFind: begin
        res.status = StatusNotFound;
        for (i = int'(first_pos); i < list_len; i++) begin
          if (!hit && list_mem[i] == value) begin
            hit             = 1'b1;
            res.status      = StatusOk;
            res.found_index = i[3:0];
          end
        end
      end
      default: ;
    endcase
    res.element_count = list_len[4:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Drive one request beat and hold it until the block takes it
  task automatic send_request(logic [2:0] mode, logic [31:0] value, logic [3:0] first_pos);
    req_mode        <= mode;
    req_value       <= value;
    req_start_index <= first_pos;
    req_start       <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_results.push_back(apply_list_request(mode, value, first_pos));
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      req_start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Result checker: every strobe is matched against the oldest expectation
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with nothing outstanding", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (found_index_o !== want.found_index)
          report_mismatch("found_index", found_index_o, want.found_index);
        if (element_count_o !== want.element_count)
          report_mismatch("element_count", element_count_o, want.element_count);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return 32'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  // Pops and finds on an empty list
  task automatic test_empty_list();
    send_request(ModePopBack, 32'h0, 4'd0);
    send_request(ModePopFront, 32'hFFFF_FFFF, 4'd15);
    send_request(ModeFind, 32'h0, 4'd0);
    send_request(ModeFind, 32'h8000_0000, 4'd15);
    idle_gap(3);
  endtask

  // Extreme words at both ends, finds that hit, miss and start past the end
  task automatic test_field_extremes();
    send_request(ModePushBack, 32'h7FFF_FFFF, 4'd0);
    send_request(ModePushFront, 32'h8000_0000, 4'd15);
    send_request(ModePushBack, 32'hFFFF_FFFF, 4'd0);
    send_request(ModePushFront, 32'h0000_0000, 4'd0);
    send_request(ModeFind, 32'hFFFF_FFFF, 4'd0);
    send_request(ModeFind, 32'h8000_0000, 4'd2);
    send_request(ModeFind, 32'h0000_0000, 4'd0);
    send_request(ModeFind, 32'h7FFF_FFFF, 4'd15);
    send_request(ModeFind, 32'h1234_5678, 4'd0);
    send_request(ModePopFront, 32'h0, 4'd0);
    send_request(ModePopBack, 32'h0, 4'd0);
    idle_gap(2);
  endtask

  // Spare codes leave the list alone
  task automatic test_unused_modes();
    send_request(ModeSpare5, 32'hFFFF_FFFF, 4'd15);
    send_request(ModeSpare6, 32'h0, 4'd0);
    send_request(ModeSpare7, 32'hA5A5_5A5A, 4'd7);
    idle_gap(1);
  endtask

  // Bursts that grow, shrink or churn the list, with repeated values for finds
  task automatic test_random_sequences();
    int          items;
    int          burst_len;
    int          phase;
    int          roll;
    int          n;
    logic [2:0]  mode;
    logic [31:0] value;
    logic [3:0]  first_pos;
    items = 0;
    while (items < RandomItems) begin
      burst_len = $urandom_range(1, 12);
      phase     = $urandom_range(0, 2);
      for (n = 0; n < burst_len; n++) begin
        roll = $urandom_range(0, 99);
        case (phase)
          0: mode = (roll < 35) ? ModePushBack : (roll < 68) ? ModePushFront :
                    (roll < 74) ? ModePopBack : (roll < 80) ? ModePopFront :
                    (roll < 97) ? ModeFind : 3'($urandom_range(5, 7));
          1: mode = (roll < 8) ? ModePushBack : (roll < 16) ? ModePushFront :
                    (roll < 45) ? ModePopBack : (roll < 75) ? ModePopFront :
                    (roll < 97) ? ModeFind : 3'($urandom_range(5, 7));
          default: mode = (roll < 20) ? ModePushBack : (roll < 40) ? ModePushFront :
                          (roll < 52) ? ModePopBack : (roll < 64) ? ModePopFront :
                          (roll < 97) ? ModeFind : 3'($urandom_range(5, 7));
        endcase
        value     = pick_value();
        first_pos = 4'($urandom_range(0, 15));
        if (mode == ModeFind) begin
          if (list_len > 0 && $urandom_range(0, 9) < 7)
            value = list_mem[$urandom_range(0, list_len - 1)];
          if (list_len > 0 && $urandom_range(0, 9) < 6)
            first_pos = 4'($urandom_range(0, list_len - 1));
        end
        send_request(mode, value, first_pos);
        if (mode <= ModeFind) items++;
      end
      // about a third of bursts run straight into the next one
      idle_gap(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_field_extremes();
    test_unused_modes();
    test_random_sequences();
    req_start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
